### hdl/dnws_pkg.sv
// ----------------------------------------------------------------------------
// dnws_pkg
// Shared types and constants of the directional nearest window selector:
// search directions, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dnws_pkg;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIRECTION     = 3'd0,
    REG_SOURCE_X      = 3'd1,
    REG_SOURCE_Y      = 3'd2,
    REG_SOURCE_WIDTH  = 3'd3,
    REG_SOURCE_HEIGHT = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_e;

  localparam int unsigned SCREEN_WIDTH_RST  = 1920;
  localparam int unsigned SCREEN_HEIGHT_RST = 1080;

endpackage

`default_nettype wire

### hdl/dnws_cfg_if.sv
// ----------------------------------------------------------------------------
// dnws_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnws_cfg_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic [dnws_pkg::CFG_IDX_BITS-1:0] reg_index;
  logic [COORD_BITS-1:0]            wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### hdl/dnws_win_if.sv
// ----------------------------------------------------------------------------
// dnws_win_if
// Candidate window channel: one rectangle with its flags per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnws_win_if #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ID_BITS    = 32
);
  logic                         valid;
  logic                         ready;
  logic [ID_BITS-1:0]           window_id;
  logic signed [COORD_BITS-1:0] window_x;
  logic signed [COORD_BITS-1:0] window_y;
  logic [COORD_BITS-2:0]        window_width;
  logic [COORD_BITS-2:0]        window_height;
  logic                         eligible;
  logic                         is_source;
  logic                         last;

  modport source (
    output valid, output window_id, output window_x, output window_y,
    output window_width, output window_height, output eligible,
    output is_source, output last, input ready
  );
  modport sink (
    input valid, input window_id, input window_x, input window_y,
    input window_width, input window_height, input eligible,
    input is_source, input last, output ready
  );
endinterface

`default_nettype wire

### hdl/dnws_res_if.sv
// ----------------------------------------------------------------------------
// dnws_res_if
// Result channel: found flag and chosen window identifier.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnws_res_if #(
  parameter int unsigned ID_BITS = 32
);
  logic               valid;
  logic               ready;
  logic               found;
  logic [ID_BITS-1:0] target_id;

  modport source (output valid, output found, output target_id, input ready);
  modport sink   (input valid, input found, input target_id, output ready);
endinterface

`default_nettype wire

### hdl/directional_nearest_window_select.sv
// ----------------------------------------------------------------------------
// directional_nearest_window_select
// Picks the candidate window nearest to a source rectangle in one direction.
//
// Usage: program direction, source rectangle and screen size on cfg_i while
// the block is idle (cfg_i.ready is always high). Stream candidates on win_i;
// mark the final one of a search with last. On that transaction a single
// result leaves on res_o with found and target_id (0 when nothing was found),
// and the running choice is cleared for the next search. Other candidates
// produce no result.
// A last candidate is registered in the input stage, its result in the result
// register behind res_o.valid. Throughput: one candidate per cycle unless
// stalled, set by the input register feeding the single compare/update stage.
// Stall: the result register holds while res_o.ready is low; candidates keep
// flowing until a second last candidate reaches the update stage, which then
// holds and drops win_i.ready.
// Reset: configuration returns to direction down, source at origin with zero
// size, screen 1920 by 1080; the running choice and both stages are emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_nearest_window_select #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ID_BITS    = 32
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  dnws_cfg_if.sink      cfg_i,
  dnws_win_if.sink      win_i,
  dnws_res_if.source    res_o
);

  localparam int unsigned EW = COORD_BITS + 2;
  localparam int unsigned SW = COORD_BITS - 1;

  // configuration
  dnws_pkg::dir_e        dir_q;
  logic signed [COORD_BITS-1:0] src_x_q, src_y_q;
  logic [SW-1:0]         src_w_q, src_h_q, scr_w_q, scr_h_q;

  // input stage
  logic                  s1_valid_q;
  logic [ID_BITS-1:0]    s1_id_q;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic [SW-1:0]         s1_w_q, s1_h_q;
  logic                  s1_elig_q, s1_src_q, s1_last_q;

  // running choice
  logic                  have_q, have_d;
  logic                  locked_q, locked_d;
  logic [ID_BITS-1:0]    best_id_q, best_id_d;
  logic signed [EW-1:0]  best_dist_q, best_dist_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic                  found_q;
  logic [ID_BITS-1:0]    target_q;

  logic s1_adv, s1_report;

  logic signed [EW-1:0] wx, wy, ww, wh, sx0, sy0, sw, sh, scw, sch;
  logic signed [EW-1:0] cx, cy, scx, scy, delta;
  logic offscreen, lateral, consider, take_zero, take_pos;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= dnws_pkg::DIR_DOWN;
      src_x_q <= '0;
      src_y_q <= '0;
      src_w_q <= '0;
      src_h_q <= '0;
      scr_w_q <= SW'(dnws_pkg::SCREEN_WIDTH_RST);
      scr_h_q <= SW'(dnws_pkg::SCREEN_HEIGHT_RST);
    end else if (cfg_i.valid) begin
      unique case (dnws_pkg::reg_idx_e'(cfg_i.reg_index))
        dnws_pkg::REG_DIRECTION:     dir_q   <= dnws_pkg::dir_e'(cfg_i.wdata[1:0]);
        dnws_pkg::REG_SOURCE_X:      src_x_q <= cfg_i.wdata;
        dnws_pkg::REG_SOURCE_Y:      src_y_q <= cfg_i.wdata;
        dnws_pkg::REG_SOURCE_WIDTH:  src_w_q <= cfg_i.wdata[SW-1:0];
        dnws_pkg::REG_SOURCE_HEIGHT: src_h_q <= cfg_i.wdata[SW-1:0];
        dnws_pkg::REG_SCREEN_WIDTH:  scr_w_q <= cfg_i.wdata[SW-1:0];
        dnws_pkg::REG_SCREEN_HEIGHT: scr_h_q <= cfg_i.wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // advance the update stage unless a report would overwrite a waiting result
  assign s1_adv      = s1_valid_q && (!s1_last_q || !out_valid_q || res_o.ready);
  assign s1_report   = s1_adv && s1_last_q;
  assign win_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (win_i.ready) begin
      s1_valid_q <= win_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_i.valid && win_i.ready) begin
      s1_id_q   <= win_i.window_id;
      s1_x_q    <= win_i.window_x;
      s1_y_q    <= win_i.window_y;
      s1_w_q    <= win_i.window_width;
      s1_h_q    <= win_i.window_height;
      s1_elig_q <= win_i.eligible;
      s1_src_q  <= win_i.is_source;
      s1_last_q <= win_i.last;
    end
  end

  always_comb begin
    wx  = {{2{s1_x_q[COORD_BITS-1]}}, s1_x_q};
    wy  = {{2{s1_y_q[COORD_BITS-1]}}, s1_y_q};
    ww  = {3'b000, s1_w_q};
    wh  = {3'b000, s1_h_q};
    sx0 = {{2{src_x_q[COORD_BITS-1]}}, src_x_q};
    sy0 = {{2{src_y_q[COORD_BITS-1]}}, src_y_q};
    sw  = {3'b000, src_w_q};
    sh  = {3'b000, src_h_q};
    scw = {3'b000, scr_w_q};
    sch = {3'b000, scr_h_q};

    cx  = wx + {4'b0000, s1_w_q[SW-1:1]};
    cy  = wy + {4'b0000, s1_h_q[SW-1:1]};
    scx = sx0 + {4'b0000, src_w_q[SW-1:1]};
    scy = sy0 + {4'b0000, src_h_q[SW-1:1]};

    offscreen = (wx + ww <= 0) || (wy + wh <= 0) || (wx >= scw) || (wy >= sch);

    unique case (dir_q)
      dnws_pkg::DIR_DOWN: begin
        delta   = cy - scy;
        lateral = (cx >= sx0) && (cx <= sx0 + sw);
      end
      dnws_pkg::DIR_LEFT: begin
        delta   = scx - cx;
        lateral = (cy >= sy0) && (cy <= sy0 + sh);
      end
      dnws_pkg::DIR_RIGHT: begin
        delta   = cx - scx;
        lateral = (cy >= sy0) && (cy <= sy0 + sh);
      end
      default: begin
        delta   = scy - cy;
        lateral = (cx >= sx0) && (cx <= sx0 + sw);
      end
    endcase

    consider  = s1_adv && !s1_src_q && s1_elig_q && !offscreen && lateral;
    take_zero = consider && (delta == 0) && !have_q;
    take_pos  = consider && (delta > 0) && (!have_q || (!locked_q && delta < best_dist_q));

    have_d      = have_q || take_zero || take_pos;
    locked_d    = locked_q || take_zero;
    best_id_d   = (take_zero || take_pos) ? s1_id_q : best_id_q;
    best_dist_d = take_pos ? delta : best_dist_q;

    out_valid_d = s1_report ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      locked_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      have_q      <= s1_report ? 1'b0 : have_d;
      locked_q    <= s1_report ? 1'b0 : locked_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_id_q   <= best_id_d;
    best_dist_q <= best_dist_d;
    if (s1_report) begin
      found_q  <= have_d;
      target_q <= have_d ? best_id_d : '0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.found     = found_q;
  assign res_o.target_id = target_q;

  a_locked_has_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |-> have_q) else $error("locked choice without target");

  a_clear_after_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_report |=> (!have_q && !locked_q)) else $error("choice not cleared");

  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s1_report))
    else $error("result without last candidate");

  a_zero_id_when_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (target_q == '0)) else $error("nonzero id");

  a_hold_on_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !res_o.ready) |-> !win_i.ready)
    else $error("accepted while report blocked");

endmodule

`default_nettype wire

### tb/dnws_selection_checker.sv
// ----------------------------------------------------------------------------
// dnws_selection_checker
// Watches the configuration, candidate and result channels of the directional
// nearest window selector. Keeps its own copy of the registers and of the
// running choice. For each candidate marked last it queues the expected
// found/target_id pair, and it compares every result transaction against the
// oldest queued pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dnws_selection_checker #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ID_BITS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dnws_cfg_if  cfg_i,
  dnws_win_if  win_i,
  dnws_res_if  res_i,
  output int   mismatch_count_o,
  output int   open_results_o
);
  import dnws_pkg::*;

  typedef struct packed {
    logic               found;
    logic [ID_BITS-1:0] target_id;
  } choice_t;

  choice_t            choice_q[$];
  dir_e               dir;
  longint             src_x, src_y, src_w, src_h, scr_w, scr_h;
  logic               have_choice;
  logic [ID_BITS-1:0] choice_id;
  longint             choice_offset;
  int                 mismatches = 0;

  function automatic void clear_choice();
    have_choice   = 1'b0;
    choice_id     = '0;
    choice_offset = -1;
  endfunction

  function automatic void rank_candidate(input logic [ID_BITS-1:0] id,
                                         input longint x, y, w, h,
                                         input logic elig, src, fin);
    longint cx, cy, scx, scy, offset;
    logic   off, lateral;
    off = (x + w <= 0) || (y + h <= 0) || (x >= scr_w) || (y >= scr_h);
    if (!src && elig && !off) begin
      cx  = x + w / 2;
      cy  = y + h / 2;
      scx = src_x + src_w / 2;
      scy = src_y + src_h / 2;
      if (dir == DIR_DOWN || dir == DIR_UP) begin
        lateral = (cx >= src_x) && (cx <= src_x + src_w);
      end else begin
        lateral = (cy >= src_y) && (cy <= src_y + src_h);
      end
      case (dir)
        DIR_DOWN:  offset = cy - scy;
        DIR_LEFT:  offset = scx - cx;
        DIR_RIGHT: offset = cx - scx;
        default:   offset = scy - cy;
      endcase
      if (lateral) begin
        if (offset == 0) begin
          // zero offset locks the choice: its offset stays at the sentinel
          if (!have_choice) begin
            have_choice = 1'b1;
            choice_id   = id;
          end
        end else if (offset > 0 && (!have_choice || offset < choice_offset)) begin
          have_choice   = 1'b1;
          choice_id     = id;
          choice_offset = offset;
        end
      end
    end
    if (fin) begin
      choice_q.push_back('{found: have_choice, target_id: have_choice ? choice_id : '0});
      clear_choice();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    choice_t want;
    if (!rst_ni) begin
      dir   = DIR_DOWN;
      src_x = 0;
      src_y = 0;
      src_w = 0;
      src_h = 0;
      scr_w = SCREEN_WIDTH_RST;
      scr_h = SCREEN_HEIGHT_RST;
      clear_choice();
      choice_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (choice_q.size() == 0) begin
          $error("unexpected result: found %0b target_id 0x%0h", res_i.found,
                 res_i.target_id);
          mismatches++;
        end else begin
          want = choice_q.pop_front();
          if (res_i.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, res_i.found);
            mismatches++;
          end
          if (res_i.target_id !== want.target_id) begin
            $error("target_id: expected 0x%0h, actual 0x%0h", want.target_id,
                   res_i.target_id);
            mismatches++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (reg_idx_e'(cfg_i.reg_index))
          REG_DIRECTION:     dir   = dir_e'(cfg_i.wdata[1:0]);
          REG_SOURCE_X:      src_x = longint'($signed(cfg_i.wdata));
          REG_SOURCE_Y:      src_y = longint'($signed(cfg_i.wdata));
          REG_SOURCE_WIDTH:  src_w = longint'(cfg_i.wdata[COORD_BITS-2:0]);
          REG_SOURCE_HEIGHT: src_h = longint'(cfg_i.wdata[COORD_BITS-2:0]);
          REG_SCREEN_WIDTH:  scr_w = longint'(cfg_i.wdata[COORD_BITS-2:0]);
          REG_SCREEN_HEIGHT: scr_h = longint'(cfg_i.wdata[COORD_BITS-2:0]);
          default: ;
        endcase
      end
      if (win_i.valid && win_i.ready) begin
        rank_candidate(win_i.window_id, longint'(win_i.window_x),
                       longint'(win_i.window_y), longint'(win_i.window_width),
                       longint'(win_i.window_height), win_i.eligible,
                       win_i.is_source, win_i.last);
      end
    end
    mismatch_count_o <= mismatches;
    open_results_o   <= choice_q.size();
  end

endmodule

### tb/tb_directional_nearest_window_select.sv
// ----------------------------------------------------------------------------
// tb_directional_nearest_window_select
// Drives configuration writes and candidate windows into the directional
// nearest window selector with random source and sink idling. A directed
// sequence covers the skip rules, ties, the zero-offset lock and the field
// extremes; random phases then sweep all directions and several source and
// screen settings, mostly with candidates placed around the source.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_directional_nearest_window_select;
  import dnws_pkg::*;

  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned ID_BITS     = 32;
  localparam int          CYCLE_LIMIT = 500000;

  logic clk_i;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycle_count = 0;
  int   mismatch_count;
  int   open_results;

  dnws_cfg_if #(.COORD_BITS(COORD_BITS))                    cfg_if ();
  dnws_win_if #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) win_if ();
  dnws_res_if #(.ID_BITS(ID_BITS))                          res_if ();

  directional_nearest_window_select #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .win_i (win_if),
    .res_o (res_if)
  );

  dnws_selection_checker #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_if),
    .win_i           (win_if),
    .res_i           (res_if),
    .mismatch_count_o(mismatch_count),
    .open_results_o  (open_results)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_directional_nearest_window_select: errors");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input int data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data[COORD_BITS-1:0];
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
  endtask

  task automatic load_setup(input dir_e d, input int sx, sy, sw, sh, scw, sch);
    write_reg(REG_DIRECTION, int'(d));
    write_reg(REG_SOURCE_X, sx);
    write_reg(REG_SOURCE_Y, sy);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_SCREEN_WIDTH, scw);
    write_reg(REG_SCREEN_HEIGHT, sch);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_candidate(input logic [ID_BITS-1:0] id, input int x, y, w, h,
                                input bit elig, src, fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      win_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    win_if.valid         <= 1'b1;
    win_if.window_id     <= id;
    win_if.window_x      <= x[COORD_BITS-1:0];
    win_if.window_y      <= y[COORD_BITS-1:0];
    win_if.window_width  <= w[COORD_BITS-2:0];
    win_if.window_height <= h[COORD_BITS-2:0];
    win_if.eligible      <= elig;
    win_if.is_source     <= src;
    win_if.last          <= fin;
    do @(posedge clk_i); while (win_if.ready !== 1'b1);
  endtask

  task automatic drain();
    win_if.valid <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_phase(input int k, input int n_items);
    dir_e d;
    int   sx, sy, sw, sh, scw, sch;
    int   sent, batch, lo, span, lat, offset, cx, cy, w, h;
    bit   elig, src;
    d = dir_e'(k % 4);
    case (k)
      1: begin
        sx = -32768; sy = 32767; sw = 32767; sh = 32767; scw = 32767; sch = 32767;
      end
      4: begin
        sx = 0; sy = 0; sw = 0; sh = 0; scw = 1; sch = 1;
      end
      7: begin
        sx = 300; sy = 300; sw = 200; sh = 200; scw = 0; sch = 0;
      end
      10: begin
        sx = 32767; sy = -32768; sw = 0; sh = 0; scw = 32767; sch = 32767;
      end
      default: begin
        sx  = $urandom_range(0, 1600);
        sy  = $urandom_range(0, 900);
        sw  = $urandom_range(0, 400);
        sh  = $urandom_range(0, 300);
        scw = $urandom_range(640, 4000);
        sch = $urandom_range(480, 3000);
      end
    endcase
    load_setup(d, sx, sy, sw, sh, scw, sch);
    sent = 0;
    while (sent < n_items) begin
      batch = $urandom_range(1, 8);
      for (int i = 0; i < batch; i++) begin
        if ($urandom_range(99) < 75) begin
          w      = $urandom_range(0, 400);
          h      = $urandom_range(0, 400);
          offset = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(0, 700)) - 100;
          lo     = (d == DIR_DOWN || d == DIR_UP) ? sx : sy;
          span   = (d == DIR_DOWN || d == DIR_UP) ? sw : sh;
          lat    = lo + int'($urandom_range(0, span + 20)) - 10;
          case (d)
            DIR_DOWN: begin
              cx = lat;
              cy = sy + sh / 2 + offset;
            end
            DIR_UP: begin
              cx = lat;
              cy = sy + sh / 2 - offset;
            end
            DIR_RIGHT: begin
              cy = lat;
              cx = sx + sw / 2 + offset;
            end
            default: begin
              cy = lat;
              cx = sx + sw / 2 - offset;
            end
          endcase
          elig = ($urandom_range(9) != 0);
          src  = ($urandom_range(19) == 0);
          send_candidate($urandom, cx - w / 2, cy - h / 2, w, h, elig, src,
                         i == batch - 1);
        end else begin
          send_candidate($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(1), $urandom_range(1), i == batch - 1);
        end
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    rst_ni               = 1'b0;
    tx_idle_pct          = 36;
    rx_idle_pct          = 85;
    cfg_if.valid         = 1'b0;
    cfg_if.reg_index     = REG_DIRECTION;
    cfg_if.wdata         = '0;
    win_if.valid         = 1'b0;
    win_if.window_id     = '0;
    win_if.window_x      = '0;
    win_if.window_y      = '0;
    win_if.window_width  = '0;
    win_if.window_height = '0;
    win_if.eligible      = 1'b0;
    win_if.is_source     = 1'b0;
    win_if.last          = 1'b0;
    res_if.ready         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setup: zero-size source at the origin
    send_candidate(32'h0000_00a5, -1, 10, 2, 0, 1'b1, 1'b0, 1'b1);
    drain();

    write_reg(REG_UNUSED, 16'h5a5a);
    load_setup(DIR_DOWN, 100, 100, 200, 100, 1920, 1080);
    send_candidate(1, 150, 300, 100, 100, 1'b1, 1'b1, 1'b0);
    send_candidate(2, 150, 300, 100, 100, 1'b0, 1'b0, 1'b0);
    send_candidate(3, -50, 300, 50, 100, 1'b1, 1'b0, 1'b0);
    send_candidate(4, 150, 1080, 100, 100, 1'b1, 1'b0, 1'b0);
    send_candidate(5, 350, 300, 100, 100, 1'b1, 1'b0, 1'b0);
    send_candidate(6, 150, 0, 100, 100, 1'b1, 1'b0, 1'b0);
    send_candidate(7, 150, 200, 100, 100, 1'b1, 1'b0, 1'b0);
    send_candidate(8, 150, 200, 100, 100, 1'b1, 1'b0, 1'b0);
    send_candidate(9, 150, 150, 100, 100, 1'b1, 1'b0, 1'b1);
    send_candidate(10, 150, 100, 100, 100, 1'b1, 1'b0, 1'b0);
    send_candidate(11, 150, 160, 100, 0, 1'b1, 1'b0, 1'b1);
    send_candidate(12, 150, 300, 100, 100, 1'b0, 1'b0, 1'b1);
    send_candidate(13, 150, 200, 100, 0, 1'b1, 1'b0, 1'b0);
    send_candidate(14, 150, 150, 100, 0, 1'b1, 1'b0, 1'b1);
    send_candidate('1, -32768, -32768, 32767, 32767, 1'b1, 1'b0, 1'b0);
    send_candidate('0, 32767, 32767, 0, 0, 1'b1, 1'b0, 1'b0);
    send_candidate('0, 150, 200, 0, 32767, 1'b1, 1'b0, 1'b1);
    send_candidate('1, 199, 250, 2, 0, 1'b1, 1'b0, 1'b0);
    send_candidate(32'h8000_0001, 300, 200, 0, 0, 1'b1, 1'b0, 1'b1);
    send_candidate(20, 99, 300, 0, 0, 1'b1, 1'b0, 1'b1);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 85 : 0;
      rx_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 36 : 0;
      for (int p = 0; p < 4; p++) begin
        random_phase(mode * 4 + p, 120);
      end
    end

    if (mismatch_count == 0 && open_results == 0) begin
      $display("tb_directional_nearest_window_select: clean");
    end else begin
      $display("tb_directional_nearest_window_select: errors");
    end
    $finish;
  end

endmodule
